// ----- rtl/tbc_pkg.sv -----
package tbc_pkg;

  localparam int ENTRIES = 64;
  localparam int BITMAP_WORDS = 16;
  localparam int PTR_W = $clog2(ENTRIES);

  localparam logic [2:0] FUNC_ADD = 3'd0;
  localparam logic [2:0] FUNC_CHECK = 3'd1;
  localparam logic [2:0] FUNC_INV_ADDR = 3'd2;
  localparam logic [2:0] FUNC_INV_RANGE = 3'd3;
  localparam logic [2:0] FUNC_CLEAR = 3'd4;

  localparam logic [1:0] KIND_INVALID = 2'd0;
  localparam logic [1:0] KIND_ARM = 2'd1;

  localparam logic [3:0] MASK_WORD = 4'd15;
  localparam logic [3:0] MASK_LOW3 = 4'd7;

  typedef struct packed {
    logic [2:0]  func;
    logic [5:0]  index;
    logic [31:0] start_address;
    logic [31:0] end_address;
    logic [31:0] saved_instruction;
    logic [1:0]  entry_type;
    logic [31:0] handler_tag;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] handler_out;
    logic        patch_valid;
    logic [31:0] patch_address;
    logic [31:0] patch_data;
    logic [3:0]  patch_byte_mask;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] start_addr;
    logic [31:0] end_addr;
    logic [31:0] saved_word;
    logic [31:0] handler;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic        set;
    logic        clr_all;
    logic [31:0] set_addr;
  } bm_ctl_t;

endpackage

// ----- rtl/tbc_ram.sv -----
module tbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/tbc_bitmap.sv -----
module tbc_bitmap (
  input  logic            clk,
  input  logic            rst_n,
  input  tbc_pkg::bm_ctl_t ctl,
  input  logic [31:0]     look_addr,
  output logic            look_hit
);
  import tbc_pkg::*;

  // One bit per 8 MiB: word from address bits 31:28, bit from 27:23.
  logic [31:0] bm_r [BITMAP_WORDS];

  assign look_hit = bm_r[look_addr[31:28]][look_addr[27:23]];

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr_all) begin
      for (int w = 0; w < BITMAP_WORDS; w++) begin
        bm_r[w] <= '0;
      end
    end else if (ctl.set) begin
      bm_r[ctl.set_addr[31:28]][ctl.set_addr[27:23]] <= 1'b1;
    end
  end

endmodule

// ----- rtl/translated_block_cache_table_top.sv -----
// Translated-block cache table: 64 slots held in one single-port-read RAM,
// with per-slot valid flops and a 512-bit region bitmap cleared at reset. A
// check reads its slot and an add writes it; an add that displaces a valid
// block, an invalidation by range, a clear and an invalidation by address
// that hits the bitmap walk the RAM one slot per cycle. One request is in
// work at a time; results leave through a one-deep output register, and a
// walk pauses only when a second patch is found while that register is full.
module translated_block_cache_table_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  tbc_pkg::req_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output tbc_pkg::rsp_t  out_data
);
  import tbc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SLOT   = 5'b00010,
    ST_CONFL  = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_FIN    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  req_t req_r, req_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [ENTRIES-1:0] vld_r, vld_nxt;
  rsp_t pend_r, pend_nxt;
  logic pend_v_r, pend_v_nxt;
  rsp_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;
  entry_t old_r, old_nxt;

  logic [PTR_W-1:0] rd_addr;
  logic [ENTRY_W-1:0] rd_raw;
  entry_t rd_ent;
  logic wr_en;
  entry_t wr_ent;
  logic [PTR_W-1:0] slot;
  bm_ctl_t bm_ctl;
  logic bm_hit;

  logic in_acc, out_free, push;
  rsp_t push_data;
  logic in_range, live, last_ptr, match, emit;
  rsp_t restore;

  tbc_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot),
    .wr_data (wr_ent),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  tbc_bitmap u_bitmap (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (bm_ctl),
    .look_addr (in_data.start_address),
    .look_hit  (bm_hit)
  );

  assign rd_ent = entry_t'(rd_raw);
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign slot = req_r.index[PTR_W-1:0];
  assign in_range = {1'b0, in_data.index} < 7'(ENTRIES);
  assign last_ptr = (ptr_r == PTR_W'(ENTRIES - 1));
  // A slot counts as live once written since it was last cleared or invalidated, with a nonzero kind.
  assign live = vld_r[ptr_r] && (rd_ent.kind != KIND_INVALID);

  always_comb begin
    restore = '0;
    restore.patch_valid = 1'b1;
    restore.patch_address = rd_ent.end_addr;
    restore.patch_data = rd_ent.saved_word;
    restore.patch_byte_mask = MASK_WORD;
  end

  always_comb begin
    case (req_r.func)
      FUNC_INV_ADDR:  match = live && (rd_ent.start_addr <= req_r.start_address)
                              && (rd_ent.end_addr >= req_r.start_address);
      FUNC_INV_RANGE: match = live && (rd_ent.end_addr >= req_r.start_address)
                              && (rd_ent.end_addr <= req_r.end_address);
      FUNC_CLEAR:     match = vld_r[ptr_r];
      default:        match = 1'b0;
    endcase
    emit = match && vld_r[ptr_r] && (rd_ent.kind == KIND_ARM);
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    ptr_nxt = ptr_r;
    vld_nxt = vld_r;
    pend_nxt = pend_r;
    pend_v_nxt = pend_v_r;
    old_nxt = old_r;
    rd_addr = ptr_r;
    wr_en = 1'b0;
    wr_ent = rd_ent;
    bm_ctl = '0;
    push = 1'b0;
    push_data = '0;

    case (state_r)
      ST_IDLE: begin
        rd_addr = in_data.index[PTR_W-1:0];
        if (in_acc) begin
          req_nxt = in_data;
          ptr_nxt = '0;
          case (in_data.func)
            FUNC_ADD, FUNC_CHECK: begin
              state_nxt = in_range ? ST_SLOT : ST_FIN;
            end
            FUNC_INV_ADDR: begin
              rd_addr = '0;
              state_nxt = bm_hit ? ST_SCAN : ST_FIN;
            end
            FUNC_INV_RANGE, FUNC_CLEAR: begin
              rd_addr = '0;
              state_nxt = ST_SCAN;
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end

      ST_SLOT: begin
        rd_addr = slot;
        if (req_r.func == FUNC_CHECK) begin
          if (out_free) begin
            push = 1'b1;
            push_data.hit = vld_r[slot] && (rd_ent.kind != KIND_INVALID)
                            && (rd_ent.start_addr == req_r.start_address);
            push_data.handler_out = push_data.hit ? rd_ent.handler : 32'd0;
            push_data.last = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          bm_ctl.set = 1'b1;
          bm_ctl.set_addr = req_r.end_address;
          wr_en = 1'b1;
          vld_nxt[slot] = 1'b1;
          if (vld_r[slot] && (rd_ent.kind != KIND_INVALID)
              && (rd_ent.end_addr == req_r.end_address)) begin
            wr_ent.start_addr = req_r.start_address;
            state_nxt = ST_FIN;
          end else begin
            wr_ent.kind = req_r.entry_type;
            wr_ent.start_addr = req_r.start_address;
            wr_ent.end_addr = req_r.end_address;
            wr_ent.saved_word = req_r.saved_instruction;
            wr_ent.handler = req_r.handler_tag;
            // The displaced block is kept aside while other slots are searched.
            if (vld_r[slot] && (rd_ent.kind != KIND_INVALID)) begin
              old_nxt = rd_ent;
              rd_addr = '0;
              state_nxt = ST_CONFL;
            end else begin
              state_nxt = ST_FIN;
            end
          end
        end
      end

      ST_CONFL: begin
        if ((ptr_r != slot) && live && (rd_ent.end_addr == old_r.end_addr)) begin
          pend_v_nxt = 1'b1;
          pend_nxt = '0;
          pend_nxt.patch_valid = 1'b1;
          pend_nxt.patch_address = old_r.end_addr;
          pend_nxt.patch_data = (32'(ptr_r) + 32'd1) << 8;
          pend_nxt.patch_byte_mask = MASK_LOW3;
          state_nxt = ST_FIN;
        end else if (last_ptr) begin
          if (old_r.kind == KIND_ARM) begin
            pend_v_nxt = 1'b1;
            pend_nxt = '0;
            pend_nxt.patch_valid = 1'b1;
            pend_nxt.patch_address = old_r.end_addr;
            pend_nxt.patch_data = old_r.saved_word;
            pend_nxt.patch_byte_mask = MASK_WORD;
          end
          state_nxt = ST_FIN;
        end else begin
          ptr_nxt = ptr_r + PTR_W'(1);
          rd_addr = ptr_nxt;
        end
      end

      ST_SCAN: begin
        // A new patch is held back until the next one, or the end, tells
        // whether it is the final transaction of this request.
        if (!(emit && pend_v_r && !out_free)) begin
          if (match) begin
            vld_nxt[ptr_r] = 1'b0;
          end
          if (emit) begin
            if (pend_v_r) begin
              push = 1'b1;
              push_data = pend_r;
            end
            pend_v_nxt = 1'b1;
            pend_nxt = restore;
          end
          if (last_ptr) begin
            if (req_r.func == FUNC_CLEAR) begin
              bm_ctl.clr_all = 1'b1;
            end
            state_nxt = ST_FIN;
          end else begin
            ptr_nxt = ptr_r + PTR_W'(1);
            rd_addr = ptr_nxt;
          end
        end
      end

      ST_FIN: begin
        if (out_free) begin
          push = 1'b1;
          push_data = pend_v_r ? pend_r : '0;
          push_data.last = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    out_nxt = push ? push_data : out_r;
    out_valid_nxt = push ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vld_r <= '0;
      pend_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r <= vld_nxt;
      pend_v_r <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r <= req_nxt;
    ptr_r <= ptr_nxt;
    pend_r <= pend_nxt;
    out_r <= out_nxt;
    old_r <= old_nxt;
  end

endmodule
